>>> src/mjnp_pkg.sv
// Shared constants and types for the mouse / joypad nibble port.
package mjnp_pkg;

  // Item operation codes
  localparam logic [1:0] MODE_STROBE = 2'd0;
  localparam logic [1:0] MODE_MOVE   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_IS_MOUSE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_RAPID_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_JOY_MERGE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_RAPID_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_SWAP         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAPID_PERIOD        = 3'd5;

  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_DATA_W-1:0] RAPID_PERIOD_RST = 31'd200000;

  // Nibble selector codes
  localparam logic [1:0] SEL_XH = 2'd0;
  localparam logic [1:0] SEL_XL = 2'd1;
  localparam logic [1:0] SEL_YH = 2'd2;
  localparam logic [1:0] SEL_YL = 2'd3;

  // Joypad read options
  typedef struct packed {
    logic key_joy_merge;
    logic button_rapid_enable;
    logic button_swap;
  } pad_cfg_t;

  // Joypad read results back to the top level
  typedef struct packed {
    logic       toggle;
    logic [3:0] data_nibble;
    logic [1:0] button_bits;
  } pad_res_t;

endpackage

>>> src/mjnp_pad.sv
// Joypad read path: rapid-fire phase check, pad/key merge and button swap.
module mjnp_pad (
  input  logic [7:0]                       pad_status,
  input  logic [7:0]                       key_joy_bits,
  input  logic [31:0]                      now_clock,
  input  logic [31:0]                      last_toggle_clock,
  input  logic                             rapid_phase,
  input  logic [mjnp_pkg::CFG_DATA_W-1:0]  rapid_period,
  input  mjnp_pkg::pad_cfg_t               cfg,
  output mjnp_pkg::pad_res_t               res
);

  logic [31:0] diff;
  logic        toggle;
  logic        phase;
  logic [7:0]  rap;
  logic [7:0]  ret0;
  logic [7:0]  ret1;
  logic [7:0]  ret2;
  logic [7:0]  ret3;

  // Phase flips when elapsed time is negative or past the period
  assign diff   = now_clock - last_toggle_clock;
  assign toggle = diff[31] || (diff[30:0] > rapid_period);
  assign phase  = rapid_phase ^ toggle;
  assign rap    = phase ? 8'hf0 : 8'h00;

  // Merge pad, key and rapid bits
  always_comb begin
    ret0 = pad_status | (rap & 8'h30);
    ret1 = cfg.key_joy_merge ? (ret0 & key_joy_bits) : ret0;
    ret2 = cfg.button_rapid_enable ? (ret1 | rap) : ret1;
    // buttons only read released when bits 6/7 agree
    ret3 = ret2;
    ret3[4] = ret2[4] & ret2[6];
    ret3[5] = ret2[5] & ret2[7];
  end

  always_comb begin
    res.toggle      = toggle;
    res.data_nibble = ret3[3:0];
    res.button_bits = cfg.button_swap ? {ret3[4], ret3[5]} : ret3[5:4];
  end

endmodule

>>> src/mouse_joypad_nibble_port.sv
// Top level of the mouse / joypad nibble port.
// One item is taken per clock while in_stall is low: it is captured in an input register,
// processed against the port state by short logic when it leaves that register, and a data
// read loads its result into an output register as it leaves. Strobe and movement items
// produce no result. A held result stalls the input only when the item waiting in the input
// register is itself a read. Configuration writes take effect at the next edge and are meant
// to be made with the port idle.
module mouse_joypad_nibble_port (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [mjnp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mjnp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic                              in_strobe_level,
  input  logic signed [15:0]                in_delta_x,
  input  logic signed [15:0]                in_delta_y,
  input  logic [7:0]                        in_mouse_buttons,
  input  logic [7:0]                        in_mouse_rapid_bits,
  input  logic [7:0]                        in_pad_status,
  input  logic [7:0]                        in_key_joy_bits,
  input  logic [31:0]                       in_now_clock,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_data_nibble,
  output logic [1:0]                        out_button_bits
);

  // Configuration registers
  logic                            dev_mouse_r;
  logic                            mouse_rapid_en_r;
  logic                            key_joy_merge_r;
  logic                            button_rapid_en_r;
  logic                            button_swap_r;
  logic [mjnp_pkg::CFG_DATA_W-1:0] rapid_period_r;

  // Port state
  logic [1:0]         nibble_sel_r, nibble_sel_nxt;
  logic               prev_strobe_r, prev_strobe_nxt;
  logic signed [15:0] accum_x_r, accum_x_nxt;
  logic signed [15:0] accum_y_r, accum_y_nxt;
  logic [7:0]         latched_x_r, latched_x_nxt;
  logic [7:0]         latched_y_r, latched_y_nxt;
  logic               rapid_phase_r, rapid_phase_nxt;
  logic [31:0]        last_toggle_r, last_toggle_nxt;

  // Input register
  logic               s1_valid_r;
  logic [1:0]         s1_mode_r;
  logic               s1_strobe_r;
  logic signed [15:0] s1_dx_r;
  logic signed [15:0] s1_dy_r;
  logic [7:0]         s1_mbtn_r;
  logic [7:0]         s1_mrapid_r;
  logic [7:0]         s1_pad_r;
  logic [7:0]         s1_key_r;
  logic [31:0]        s1_now_r;

  // Output register
  logic       out_valid_r;
  logic [3:0] out_data_r;
  logic [1:0] out_btn_r;

  logic       s1_is_read;
  logic       s1_fire;
  logic       in_take;
  logic       strobe_edge;
  logic [1:0] sel_inc;
  logic [3:0] res_data;
  logic [1:0] res_btn;

  mjnp_pkg::pad_cfg_t pad_cfg;
  mjnp_pkg::pad_res_t pad_res;

  // Handshake
  assign s1_is_read = (s1_mode_r == mjnp_pkg::MODE_READ);
  assign s1_fire    = s1_valid_r && (!s1_is_read || !out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_fire;
  assign in_take    = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_data_nibble = out_data_r;
  assign out_button_bits = out_btn_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_mouse_r       <= 1'b0;
      mouse_rapid_en_r  <= 1'b0;
      key_joy_merge_r   <= 1'b0;
      button_rapid_en_r <= 1'b0;
      button_swap_r     <= 1'b0;
      rapid_period_r    <= mjnp_pkg::RAPID_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mjnp_pkg::REG_DEVICE_IS_MOUSE:     dev_mouse_r       <= cfg_wdata[0];
        mjnp_pkg::REG_MOUSE_RAPID_ENABLE:  mouse_rapid_en_r  <= cfg_wdata[0];
        mjnp_pkg::REG_KEY_JOY_MERGE:       key_joy_merge_r   <= cfg_wdata[0];
        mjnp_pkg::REG_BUTTON_RAPID_ENABLE: button_rapid_en_r <= cfg_wdata[0];
        mjnp_pkg::REG_BUTTON_SWAP:         button_swap_r     <= cfg_wdata[0];
        mjnp_pkg::REG_RAPID_PERIOD:        rapid_period_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r   <= in_mode;
      s1_strobe_r <= in_strobe_level;
      s1_dx_r     <= in_delta_x;
      s1_dy_r     <= in_delta_y;
      s1_mbtn_r   <= in_mouse_buttons;
      s1_mrapid_r <= in_mouse_rapid_bits;
      s1_pad_r    <= in_pad_status;
      s1_key_r    <= in_key_joy_bits;
      s1_now_r    <= in_now_clock;
    end
  end

  // Joypad read logic
  assign pad_cfg.key_joy_merge       = key_joy_merge_r;
  assign pad_cfg.button_rapid_enable = button_rapid_en_r;
  assign pad_cfg.button_swap         = button_swap_r;

  mjnp_pad u_pad (
    .pad_status        (s1_pad_r),
    .key_joy_bits      (s1_key_r),
    .now_clock         (s1_now_r),
    .last_toggle_clock (last_toggle_r),
    .rapid_phase       (rapid_phase_r),
    .rapid_period      (rapid_period_r),
    .cfg               (pad_cfg),
    .res               (pad_res)
  );

  // Saturating 16-bit add
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      sat_add = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  // Clamp to -128..127
  function automatic logic [7:0] clamp_byte(input logic signed [15:0] v);
    if (!v[15] && (v[14:7] != 8'h00)) begin
      clamp_byte = 8'h7f;
    end else if (v[15] && (v[14:7] != 8'hff)) begin
      clamp_byte = 8'h80;
    end else begin
      clamp_byte = v[7:0];
    end
  endfunction

  // Read result: mouse nibble and buttons, or the joypad result when the device is not a mouse
  always_comb begin
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] b;
    nx = 8'h00 - latched_x_r;
    ny = 8'h00 - latched_y_r;
    case (nibble_sel_r)
      mjnp_pkg::SEL_XH: res_data = nx[7:4];
      mjnp_pkg::SEL_XL: res_data = nx[3:0];
      mjnp_pkg::SEL_YH: res_data = ny[7:4];
      default:          res_data = ny[3:0];
    endcase
    b = mouse_rapid_en_r ? (s1_mbtn_r | s1_mrapid_r) : s1_mbtn_r;
    res_btn = {b[5], b[7]};
    if (!dev_mouse_r) begin
      res_data = pad_res.data_nibble;
      res_btn  = pad_res.button_bits;
    end
  end

  // State update
  assign strobe_edge = dev_mouse_r && (s1_mode_r == mjnp_pkg::MODE_STROBE) &&
                       (s1_strobe_r != prev_strobe_r);
  assign sel_inc     = nibble_sel_r + 2'd1;

  always_comb begin
    nibble_sel_nxt  = nibble_sel_r;
    prev_strobe_nxt = prev_strobe_r;
    accum_x_nxt     = accum_x_r;
    accum_y_nxt     = accum_y_r;
    latched_x_nxt   = latched_x_r;
    latched_y_nxt   = latched_y_r;
    rapid_phase_nxt = rapid_phase_r;
    last_toggle_nxt = last_toggle_r;
    if (s1_fire) begin
      case (s1_mode_r)
        mjnp_pkg::MODE_STROBE: begin
          if (strobe_edge) begin
            prev_strobe_nxt = s1_strobe_r;
            nibble_sel_nxt  = sel_inc;
            // wrap to XH latches and clears both axes
            if (sel_inc == mjnp_pkg::SEL_XH) begin
              latched_x_nxt = clamp_byte(accum_x_r);
              latched_y_nxt = clamp_byte(accum_y_r);
              accum_x_nxt   = 16'sd0;
              accum_y_nxt   = 16'sd0;
            end
          end
        end
        mjnp_pkg::MODE_MOVE: begin
          accum_x_nxt = sat_add(accum_x_r, s1_dx_r);
          accum_y_nxt = sat_add(accum_y_r, s1_dy_r);
        end
        mjnp_pkg::MODE_READ: begin
          if (!dev_mouse_r && pad_res.toggle) begin
            rapid_phase_nxt = ~rapid_phase_r;
            last_toggle_nxt = s1_now_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_sel_r  <= mjnp_pkg::SEL_YL;
      prev_strobe_r <= 1'b0;
      accum_x_r     <= 16'sd0;
      accum_y_r     <= 16'sd0;
      latched_x_r   <= 8'h00;
      latched_y_r   <= 8'h00;
      rapid_phase_r <= 1'b0;
      last_toggle_r <= 32'd0;
    end else begin
      nibble_sel_r  <= nibble_sel_nxt;
      prev_strobe_r <= prev_strobe_nxt;
      accum_x_r     <= accum_x_nxt;
      accum_y_r     <= accum_y_nxt;
      latched_x_r   <= latched_x_nxt;
      latched_y_r   <= latched_y_nxt;
      rapid_phase_r <= rapid_phase_nxt;
      last_toggle_r <= last_toggle_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_is_read) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_read) begin
      out_data_r <= res_data;
      out_btn_r  <= res_btn;
    end
  end

  // Checks
  a_sel_only_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && (s1_mode_r == mjnp_pkg::MODE_STROBE)) |=> $stable(nibble_sel_r))
    else $error("nibble selector moved without a strobe transfer");

  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && strobe_edge && (nibble_sel_r == mjnp_pkg::SEL_YL)) |=>
      (accum_x_r == 16'sd0) && (accum_y_r == 16'sd0) && (nibble_sel_r == mjnp_pkg::SEL_XH))
    else $error("selector wrap did not latch and clear the accumulators");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_is_read) |=> out_valid_r)
    else $error("read transfer lost its result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_is_read && out_valid_r && out_stall))
    else $error("input stalled without a blocked read");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the mouse / joypad nibble port.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] MODE_IGNORED = 2'd3;  // no operation, block leaves state alone
  localparam int PIPE_SLACK = 4;               // cycles for non-result items to drain
  localparam int N_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 109;

  typedef struct packed {
    logic [1:0]         mode;
    logic               strobe;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         mbtn;
    logic [7:0]         mrap;
    logic [7:0]         pad;
    logic [7:0]         key;
    logic [31:0]        now;
  } port_item_t;

  typedef struct packed {
    logic [3:0] nib;
    logic [1:0] btn;
  } read_res_t;

  // One line of the directed table: either a register write or an item
  typedef struct packed {
    logic                            is_cfg;
    logic [mjnp_pkg::CFG_IDX_W-1:0]  idx;
    logic [mjnp_pkg::CFG_DATA_W-1:0] val;
    port_item_t                      item;
    logic                            typed;
    read_res_t                       res;
  } dir_row_t;

  // DUT connections
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [mjnp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mjnp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      in_mode = MODE_IGNORED;
  logic                            in_strobe_level = 1'b0;
  logic signed [15:0]              in_delta_x = '0;
  logic signed [15:0]              in_delta_y = '0;
  logic [7:0]                      in_mouse_buttons = '0;
  logic [7:0]                      in_mouse_rapid_bits = '0;
  logic [7:0]                      in_pad_status = '0;
  logic [7:0]                      in_key_joy_bits = '0;
  logic [31:0]                     in_now_clock = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [3:0]                      out_data_nibble;
  logic [1:0]                      out_button_bits;

  // Predicted port state and register copy
  logic                            c_mouse, c_mrapid, c_merge, c_brapid, c_swap;
  logic [mjnp_pkg::CFG_DATA_W-1:0] c_period;
  logic [1:0]                      sel;
  logic                            prev_lvl;
  logic signed [15:0]              acc_x, acc_y;
  logic [7:0]                      lat_x, lat_y;
  logic                            pad_phase;
  logic [31:0]                     pad_last_clk;
  logic [31:0]                     clk_now = '0;

  read_res_t pending_reads[$];
  read_res_t want;
  dir_row_t  plan[$];

  int n_items = 0, n_directed = 0, n_checked = 0, n_errs = 0;
  int n_writes = 0, n_settings = 0, n_toggles = 0, n_latches = 0;
  int stall_left = 0;
  int stall_style = 0;
  int cyc = 0;

  mouse_joypad_nibble_port u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_strobe_level     (in_strobe_level),
    .in_delta_x          (in_delta_x),
    .in_delta_y          (in_delta_y),
    .in_mouse_buttons    (in_mouse_buttons),
    .in_mouse_rapid_bits (in_mouse_rapid_bits),
    .in_pad_status       (in_pad_status),
    .in_key_joy_bits     (in_key_joy_bits),
    .in_now_clock        (in_now_clock),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_nibble     (out_data_nibble),
    .out_button_bits     (out_button_bits)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic [7:0] clamp8(logic signed [15:0] v);
    if (v > 127) return 8'h7f;
    if (v < -128) return 8'h80;
    return v[7:0];
  endfunction

  task automatic reset_port_state();
    c_mouse = 1'b0;
    c_mrapid = 1'b0;
    c_merge = 1'b0;
    c_brapid = 1'b0;
    c_swap = 1'b0;
    c_period = mjnp_pkg::RAPID_PERIOD_RST;
    sel = mjnp_pkg::SEL_YL;
    prev_lvl = 1'b0;
    acc_x = '0;
    acc_y = '0;
    lat_x = '0;
    lat_y = '0;
    pad_phase = 1'b0;
    pad_last_clk = '0;
  endtask

  // Advance the port state by one item; a data read yields one result
  task automatic predict_port(input port_item_t it, output logic has, output read_res_t r);
    logic [7:0]  nx, ny, b, rap, ret;
    logic [31:0] diff;
    has = 1'b0;
    r = '0;
    case (it.mode)
      mjnp_pkg::MODE_STROBE: begin
        if (c_mouse && it.strobe != prev_lvl) begin
          prev_lvl = it.strobe;
          sel = sel + 2'd1;
          // wrap to XH latches the clamped movement and starts over
          if (sel == mjnp_pkg::SEL_XH) begin
            lat_x = clamp8(acc_x);
            lat_y = clamp8(acc_y);
            acc_x = '0;
            acc_y = '0;
            n_latches++;
          end
        end
      end
      mjnp_pkg::MODE_MOVE: begin
        acc_x = sat16(int'(acc_x) + int'($signed(it.dx)));
        acc_y = sat16(int'(acc_y) + int'($signed(it.dy)));
      end
      mjnp_pkg::MODE_READ: begin
        has = 1'b1;
        if (c_mouse) begin
          nx = 8'h00 - lat_x;
          ny = 8'h00 - lat_y;
          case (sel)
            mjnp_pkg::SEL_XH: r.nib = nx[7:4];
            mjnp_pkg::SEL_XL: r.nib = nx[3:0];
            mjnp_pkg::SEL_YH: r.nib = ny[7:4];
            default:          r.nib = ny[3:0];
          endcase
          b = it.mbtn | (c_mrapid ? it.mrap : 8'h00);
          r.btn = {b[5], b[7]};
        end else begin
          // rapid phase flips on a backwards clock or when the period has passed
          diff = it.now - pad_last_clk;
          if (diff[31] || diff > {1'b0, c_period}) begin
            pad_phase = ~pad_phase;
            pad_last_clk = it.now;
            n_toggles++;
          end
          rap = pad_phase ? 8'hf0 : 8'h00;
          ret = it.pad | (rap & 8'h30);
          if (c_merge) ret &= it.key;
          if (c_brapid) ret |= rap;
          ret &= (ret >> 2) | 8'hcf;
          if (c_swap) ret = {ret[7:6], ret[4], ret[5], ret[3:0]};
          r.nib = ret[3:0];
          r.btn = ret[5:4];
        end
      end
      default: ;
    endcase
  endtask

  // Register write, port must be idle
  task automatic write_reg(input logic [mjnp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mjnp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      mjnp_pkg::REG_DEVICE_IS_MOUSE:     c_mouse = val[0];
      mjnp_pkg::REG_MOUSE_RAPID_ENABLE:  c_mrapid = val[0];
      mjnp_pkg::REG_KEY_JOY_MERGE:       c_merge = val[0];
      mjnp_pkg::REG_BUTTON_RAPID_ENABLE: c_brapid = val[0];
      mjnp_pkg::REG_BUTTON_SWAP:         c_swap = val[0];
      mjnp_pkg::REG_RAPID_PERIOD:        c_period = val;
      default: ;
    endcase
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off the sender until every read result is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // One input transfer; valid is left high for a following item
  task automatic send_item(input port_item_t it, input logic typed, input read_res_t typed_res);
    logic      has;
    read_res_t r;
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_strobe_level <= it.strobe;
    in_delta_x <= it.dx;
    in_delta_y <= it.dy;
    in_mouse_buttons <= it.mbtn;
    in_mouse_rapid_bits <= it.mrap;
    in_pad_status <= it.pad;
    in_key_joy_bits <= it.key;
    in_now_clock <= it.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_port(it, has, r);
    if (has) pending_reads.push_back(typed ? typed_res : r);
  endtask

  function automatic dir_row_t cfg_row(logic [mjnp_pkg::CFG_IDX_W-1:0] idx,
                                       logic [mjnp_pkg::CFG_DATA_W-1:0] val);
    dir_row_t row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic dir_row_t item_row(logic [1:0] mode, logic lvl, logic [15:0] dx,
                                        logic [15:0] dy, logic [7:0] mb, logic [7:0] mr,
                                        logic [7:0] pad, logic [7:0] key, logic [31:0] now);
    dir_row_t row = '0;
    row.item.mode = mode;
    row.item.strobe = lvl;
    row.item.dx = dx;
    row.item.dy = dy;
    row.item.mbtn = mb;
    row.item.mrap = mr;
    row.item.pad = pad;
    row.item.key = key;
    row.item.now = now;
    return row;
  endfunction

  function automatic dir_row_t chk(dir_row_t row, logic [3:0] nib, logic [1:0] btn);
    row.typed = 1'b1;
    row.res.nib = nib;
    row.res.btn = btn;
    return row;
  endfunction

  // Random item, biased toward complete strobe cycles in mouse mode
  task automatic make_item(output port_item_t it);
    int unsigned pick, step;
    it.mbtn = 8'($urandom);
    it.mrap = 8'($urandom);
    it.pad = 8'($urandom);
    it.key = 8'($urandom);
    it.strobe = 1'($urandom);
    case ($urandom_range(0, 9))
      0: it.dx = 16'($urandom);
      1: it.dx = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: it.dx = 16'($urandom_range(0, 600) - 300);
    endcase
    case ($urandom_range(0, 9))
      0: it.dy = 16'($urandom);
      1: it.dy = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: it.dy = 16'($urandom_range(0, 600) - 300);
    endcase
    step = (c_period < 64) ? 8 : (c_period <= 400000) ? c_period / 3 : 100000;
    case ($urandom_range(0, 9))
      0: it.now = $urandom;
      1: it.now = clk_now - $urandom_range(1, 5000);
      2: it.now = pad_last_clk + {1'b0, c_period} + $urandom_range(0, 2) - 1;
      default: it.now = clk_now + $urandom_range(0, step);
    endcase
    clk_now = it.now;
    pick = $urandom_range(0, 99);
    if (c_mouse) begin
      if (pick < 30) it.mode = mjnp_pkg::MODE_MOVE;
      else if (pick < 60) begin
        it.mode = mjnp_pkg::MODE_STROBE;
        if (pick < 56) it.strobe = ~prev_lvl;
      end
      else if (pick < 96) it.mode = mjnp_pkg::MODE_READ;
      else it.mode = MODE_IGNORED;
    end else begin
      if (pick < 15) it.mode = mjnp_pkg::MODE_MOVE;
      else if (pick < 23) it.mode = mjnp_pkg::MODE_STROBE;
      else if (pick < 96) it.mode = mjnp_pkg::MODE_READ;
      else it.mode = MODE_IGNORED;
    end
  endtask

  // Result stall: a style picked at random, held for a stretch of cycles
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cyc % 5) != 0;
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("result transfer with nothing expected: data_nibble %h button_bits %h",
               out_data_nibble, out_button_bits);
        n_errs++;
      end else begin
        want = pending_reads.pop_front();
        n_checked++;
        if (out_data_nibble !== want.nib) begin
          $error("data_nibble: expected %h, got %h", want.nib, out_data_nibble);
          n_errs++;
        end
        if (out_button_bits !== want.btn) begin
          $error("button_bits: expected %h, got %h", want.btn, out_button_bits);
          n_errs++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    port_item_t it;
    int burst, gap, target, waited;
    logic drained;
    logic [mjnp_pkg::CFG_DATA_W-1:0] per;

    reset_port_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Joypad at reset settings: ignored strobe, period boundary, backwards clock
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b1, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'hff, 8'h00,
                                8'hff, 8'h00, 0), 4'hf, 2'd3));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00,
                                8'h00, 8'hff, 200000), 4'h0, 2'd0));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'ha5,
                            8'h5a, 200001));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h5a,
                            8'ha5, 5));
    plan.push_back(item_row(MODE_IGNORED, 1'b1, 16'h1234, 16'hfedc, 8'hff, 8'hff, 8'h00,
                            8'h00, 32'hffff_ffff));
    // movement in joypad mode still accumulates
    plan.push_back(item_row(mjnp_pkg::MODE_MOVE, 1'b0, 16'h7fff, 16'h8000, 8'h00, 8'h00,
                            8'h00, 8'h00, 0));
    // All joypad options on, zero period
    plan.push_back(cfg_row(mjnp_pkg::REG_KEY_JOY_MERGE, 31'd1));
    plan.push_back(cfg_row(mjnp_pkg::REG_BUTTON_RAPID_ENABLE, 31'd1));
    plan.push_back(cfg_row(mjnp_pkg::REG_BUTTON_SWAP, 31'd1));
    plan.push_back(cfg_row(mjnp_pkg::REG_RAPID_PERIOD, 31'd0));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'hff,
                            8'h00, 5));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'hef,
                            8'hff, 6));
    // Largest period: exactly at it, then just past into negative
    plan.push_back(cfg_row(mjnp_pkg::REG_RAPID_PERIOD, 31'h7fff_ffff));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h3c,
                            8'hc3, 32'h8000_0005));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'hc3,
                            8'h3c, 32'h8000_0006));
    // Mouse: saturation, one full selector cycle, button mapping
    plan.push_back(cfg_row(mjnp_pkg::REG_DEVICE_IS_MOUSE, 31'd1));
    plan.push_back(cfg_row(mjnp_pkg::REG_MOUSE_RAPID_ENABLE, 31'd0));
    plan.push_back(cfg_row(mjnp_pkg::REG_KEY_JOY_MERGE, 31'd0));
    plan.push_back(cfg_row(mjnp_pkg::REG_BUTTON_RAPID_ENABLE, 31'd0));
    plan.push_back(cfg_row(mjnp_pkg::REG_BUTTON_SWAP, 31'd0));
    plan.push_back(item_row(mjnp_pkg::MODE_MOVE, 1'b0, 16'h7fff, 16'h8000, 8'h00, 8'h00,
                            8'h00, 8'h00, 0));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00,
                                8'h00, 8'h00, 0), 4'h0, 2'd0));
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b1, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'hff, 8'h00,
                                8'h00, 8'h00, 0), 4'h8, 2'd3));
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b1, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h20, 8'h00,
                                8'h00, 8'h00, 0), 4'h1, 2'd2));
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b1, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h80, 8'h00,
                                8'h00, 8'h00, 0), 4'h8, 2'd1));
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'h00,
                                8'h00, 8'h00, 0), 4'h0, 2'd0));
    plan.push_back(item_row(mjnp_pkg::MODE_MOVE, 1'b0, 16'hffff, 16'h0001, 8'h00, 8'h00,
                            8'h00, 8'h00, 0));
    plan.push_back(item_row(mjnp_pkg::MODE_STROBE, 1'b1, 16'h0, 16'h0, 8'h00, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h5f, 8'h00, 8'h00,
                            8'h00, 0));
    plan.push_back(cfg_row(mjnp_pkg::REG_MOUSE_RAPID_ENABLE, 31'd1));
    plan.push_back(chk(item_row(mjnp_pkg::MODE_READ, 1'b0, 16'h0, 16'h0, 8'h00, 8'ha0,
                                8'h00, 8'h00, 0), 4'h0, 2'd3));

    n_settings = 1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) begin
          settle();
          n_settings++;
        end
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].res);
        n_items++;
        n_directed++;
      end
    end

    // Random phases, each under a fresh register setting
    drained = 1'b0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 5))
        0: per = 31'd1;
        1: per = 31'h7fff_ffff;
        2: per = 31'd0;
        3: per = 31'($urandom_range(1, 64));
        4: per = mjnp_pkg::RAPID_PERIOD_RST;
        default: per = 31'($urandom);
      endcase
      write_reg(mjnp_pkg::REG_DEVICE_IS_MOUSE, (ph % 2 == 0) ? 31'd1 : 31'd0);
      write_reg(mjnp_pkg::REG_MOUSE_RAPID_ENABLE, 31'($urandom_range(0, 1)));
      write_reg(mjnp_pkg::REG_KEY_JOY_MERGE, 31'($urandom_range(0, 1)));
      write_reg(mjnp_pkg::REG_BUTTON_RAPID_ENABLE, 31'($urandom_range(0, 1)));
      write_reg(mjnp_pkg::REG_BUTTON_SWAP, 31'($urandom_range(0, 1)));
      write_reg(mjnp_pkg::REG_RAPID_PERIOD, per);
      n_settings++;
      target = n_items + ITEMS_PER_PHASE;
      while (n_items < target) begin
        burst = $urandom_range(1, 40);
        if (burst > target - n_items) burst = target - n_items;
        repeat (burst) begin
          make_item(it);
          n_items++;
          send_item(it, 1'b0, '0);
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        // in phase 5 the sender waits once, mid-phase, for every result to come back
        if (ph == 5 && !drained && n_items > target - ITEMS_PER_PHASE / 2) begin
          settle();
          drained = 1'b1;
        end
      end
    end

    // Wind down
    in_valid <= 1'b0;
    waited = 0;
    while (pending_reads.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_reads.size() != 0) begin
      $error("%0d read results never arrived", pending_reads.size());
      n_errs += pending_reads.size();
    end

    $display("Run covered %0d items (%0d directed) under %0d register settings, %0d writes.",
             n_items, n_directed, n_settings, n_writes);
    $display("Checked %0d read results; %0d rapid-fire flips, %0d movement latches.",
             n_checked, n_toggles, n_latches);
    if (n_errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
src/mjnp_pkg.sv
src/mjnp_pad.sv
src/mouse_joypad_nibble_port.sv
verif/tb.sv
